// ----- rtl/core/wlsq_pkg.sv -----
package wlsq_pkg;

    // fixed point formats of the ports
    localparam int IN_FRAC  = 16;
    localparam int ACC_FRAC = 32;
    localparam int GRAD_W   = 64;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_INVERT = 2'd2,
        OP_APPLY  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_GO,
        S_MUL_WAIT,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

    // one multiply-accumulate step of the microprogram
    typedef struct packed {
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic       sub;
        logic       first;
        logic       last;
    } mac_t;

    // operand file: six entries, six cofactors, three vector components
    localparam logic [3:0] F_ENT = 4'd0;
    localparam logic [3:0] F_COF = 4'd6;
    localparam logic [3:0] F_VEC = 4'd12;

    localparam logic [3:0] ADD_SUMSQ_LAST = 4'd2;
    localparam logic [3:0] ADD_LAST       = 4'd8;
    localparam logic [3:0] INV_DET_LAST   = 4'd14;
    localparam logic [3:0] INV_DIV_LAST   = 4'd5;
    localparam logic [3:0] APPLY_LAST     = 4'd8;

    function automatic mac_t mk(input logic [3:0] a, input logic [3:0] b,
                                input logic sub, input logic first, input logic last);
        mac_t m;
        m.a_sel = a;
        m.b_sel = b;
        m.sub   = sub;
        m.first = first;
        m.last  = last;
        return m;
    endfunction

    // entry order a11 a22 a33 a21 a31 a32
    function automatic mac_t mac_entry(input opcode_t op, input logic [3:0] step);
        mac_t m;
        m = mk(F_ENT, F_ENT, 1'b0, 1'b1, 1'b1);
        case (op)
            OP_ADD:
            begin
                case (step)
                    4'd0:    m = mk(F_VEC, F_VEC, 1'b0, 1'b1, 1'b0);
                    4'd1:    m = mk(F_VEC + 4'd1, F_VEC + 4'd1, 1'b0, 1'b0, 1'b0);
                    4'd2:    m = mk(F_VEC + 4'd2, F_VEC + 4'd2, 1'b0, 1'b0, 1'b1);
                    4'd3:    m = mk(F_VEC, F_VEC, 1'b0, 1'b1, 1'b1);
                    4'd4:    m = mk(F_VEC + 4'd1, F_VEC + 4'd1, 1'b0, 1'b1, 1'b1);
                    4'd5:    m = mk(F_VEC + 4'd2, F_VEC + 4'd2, 1'b0, 1'b1, 1'b1);
                    4'd6:    m = mk(F_VEC, F_VEC + 4'd1, 1'b0, 1'b1, 1'b1);
                    4'd7:    m = mk(F_VEC, F_VEC + 4'd2, 1'b0, 1'b1, 1'b1);
                    4'd8:    m = mk(F_VEC + 4'd1, F_VEC + 4'd2, 1'b0, 1'b1, 1'b1);
                    default: m = mk(F_ENT, F_ENT, 1'b0, 1'b1, 1'b1);
                endcase
            end
            OP_INVERT:
            begin
                case (step)
                    4'd0:    m = mk(4'd1, 4'd2, 1'b0, 1'b1, 1'b0);
                    4'd1:    m = mk(4'd5, 4'd5, 1'b1, 1'b0, 1'b1);
                    4'd2:    m = mk(4'd0, 4'd2, 1'b0, 1'b1, 1'b0);
                    4'd3:    m = mk(4'd4, 4'd4, 1'b1, 1'b0, 1'b1);
                    4'd4:    m = mk(4'd0, 4'd1, 1'b0, 1'b1, 1'b0);
                    4'd5:    m = mk(4'd3, 4'd3, 1'b1, 1'b0, 1'b1);
                    4'd6:    m = mk(4'd4, 4'd5, 1'b0, 1'b1, 1'b0);
                    4'd7:    m = mk(4'd3, 4'd2, 1'b1, 1'b0, 1'b1);
                    4'd8:    m = mk(4'd3, 4'd5, 1'b0, 1'b1, 1'b0);
                    4'd9:    m = mk(4'd1, 4'd4, 1'b1, 1'b0, 1'b1);
                    4'd10:   m = mk(4'd4, 4'd3, 1'b0, 1'b1, 1'b0);
                    4'd11:   m = mk(4'd0, 4'd5, 1'b1, 1'b0, 1'b1);
                    4'd12:   m = mk(F_COF, 4'd0, 1'b0, 1'b1, 1'b0);
                    4'd13:   m = mk(F_COF + 4'd3, 4'd3, 1'b0, 1'b0, 1'b0);
                    4'd14:   m = mk(F_COF + 4'd4, 4'd4, 1'b0, 1'b0, 1'b1);
                    default: m = mk(F_ENT, F_ENT, 1'b0, 1'b1, 1'b1);
                endcase
            end
            OP_APPLY:
            begin
                case (step)
                    4'd0:    m = mk(4'd0, F_VEC, 1'b0, 1'b1, 1'b0);
                    4'd1:    m = mk(4'd3, F_VEC + 4'd1, 1'b0, 1'b0, 1'b0);
                    4'd2:    m = mk(4'd4, F_VEC + 4'd2, 1'b0, 1'b0, 1'b1);
                    4'd3:    m = mk(4'd3, F_VEC, 1'b0, 1'b1, 1'b0);
                    4'd4:    m = mk(4'd1, F_VEC + 4'd1, 1'b0, 1'b0, 1'b0);
                    4'd5:    m = mk(4'd5, F_VEC + 4'd2, 1'b0, 1'b0, 1'b1);
                    4'd6:    m = mk(4'd4, F_VEC, 1'b0, 1'b1, 1'b0);
                    4'd7:    m = mk(4'd5, F_VEC + 4'd1, 1'b0, 1'b0, 1'b0);
                    4'd8:    m = mk(4'd2, F_VEC + 4'd2, 1'b0, 1'b0, 1'b1);
                    default: m = mk(F_ENT, F_ENT, 1'b0, 1'b1, 1'b1);
                endcase
            end
            default: m = mk(F_ENT, F_ENT, 1'b0, 1'b1, 1'b1);
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/core/wlsq_alu.sv -----
module wlsq_alu #(
    parameter int MW   = 196,
    parameter int MB_W = 64,
    parameter int SQ_N = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wlsq_pkg::alu_req_t  req,
    input  logic [MW-1:0]       a,
    input  logic [MW-1:0]       b,
    output wlsq_pkg::alu_rsp_t  rsp,
    output logic [MW-1:0]       res
);

    localparam int CNT_W = $clog2(MW + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    wlsq_pkg::alu_op_t   kind_reg, kind_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MW-1:0]       x_reg, x_next;
    logic [MW-1:0]       y_reg, y_next;
    logic [MW:0]         r_reg, r_next;
    logic [MW-1:0]       q_reg, q_next;

    always_comb
    begin
        logic [MW:0] rsh;
        logic [MW:0] trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        kind_next = kind_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        rsh       = '0;
        trial     = '0;
        if (req.start)
        begin
            busy_next = 1'b1;
            kind_next = req.op;
            x_next    = a;
            y_next    = b;
            r_next    = '0;
            q_next    = '0;
            case (req.op)
                wlsq_pkg::ALU_MUL:  cnt_next = CNT_W'(MB_W);
                wlsq_pkg::ALU_DIV:  cnt_next = CNT_W'(MW);
                wlsq_pkg::ALU_SQRT: cnt_next = CNT_W'(SQ_N);
                default:            cnt_next = CNT_W'(1);
            endcase
        end
        else if (busy_reg)
        begin
            case (kind_reg)
                wlsq_pkg::ALU_MUL:
                begin
                    // shift-add, one multiplier bit a cycle
                    if (y_reg[0])
                    begin
                        r_next = r_reg + {1'b0, x_reg};
                    end
                    x_next = x_reg << 1;
                    y_next = y_reg >> 1;
                end
                wlsq_pkg::ALU_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    rsh = {r_reg[MW-1:0], x_reg[MW-1]};
                    if (rsh >= {1'b0, y_reg})
                    begin
                        r_next = rsh - {1'b0, y_reg};
                        q_next = {q_reg[MW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next = rsh;
                        q_next = {q_reg[MW-2:0], 1'b0};
                    end
                    x_next = x_reg << 1;
                end
                wlsq_pkg::ALU_SQRT:
                begin
                    // digit-by-digit root, two radicand bits a cycle
                    rsh   = {r_reg[MW-2:0], x_reg[2*SQ_N-1 -: 2]};
                    trial = {q_reg[MW-2:0], 2'b01};
                    if (rsh >= trial)
                    begin
                        r_next = rsh - trial;
                        q_next = {q_reg[MW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next = rsh;
                        q_next = {q_reg[MW-2:0], 1'b0};
                    end
                    x_next = x_reg << 2;
                end
                default:
                begin
                    q_next = '0;
                end
            endcase
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            kind_reg <= wlsq_pkg::ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            kind_reg <= kind_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign res      = (kind_reg == wlsq_pkg::ALU_MUL) ? r_reg[MW-1:0] : q_reg;
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

endmodule

// ----- rtl/core/weighted_lsq_gradient_solver.sv -----
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// input     | in_valid, in_stall | opcode, vec_x, vec_y, vec_z
// output    | out_valid,out_stall| result_kind, grad_x, grad_y, grad_z, singular
//
// one request at a time; in_stall stays high until the sequencer is back in idle
// clear is done in idle; others run on the shared unit (magnitude width 196 at defaults)
// add: 3 multiplies, one root, 6 multiply/divide pairs (only the 3 if zero offset)
// invert: 15 multiplies, 6 divides, hand-off (no divides if singular)
// apply: 9 multiplies, hand-off; a held output keeps the sequencer in hand-off
// asynchronous active-low reset clears control state, output valid and the matrix entries
module weighted_lsq_gradient_solver #(
    parameter int COORD_WIDTH = 32,
    parameter int ACC_WIDTH   = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic signed [COORD_WIDTH-1:0]       vec_x,
    input  logic signed [COORD_WIDTH-1:0]       vec_y,
    input  logic signed [COORD_WIDTH-1:0]       vec_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                result_kind,
    output logic signed [wlsq_pkg::GRAD_W-1:0]  grad_x,
    output logic signed [wlsq_pkg::GRAD_W-1:0]  grad_y,
    output logic signed [wlsq_pkg::GRAD_W-1:0]  grad_z,
    output logic                                singular
);

    localparam int GW     = wlsq_pkg::GRAD_W;
    // magnitude width: determinant, shifted cofactor, shifted add product
    localparam int MW_DET = 3 * ACC_WIDTH + 4;
    localparam int MW_INV = 2 * ACC_WIDTH + 2 * wlsq_pkg::ACC_FRAC + 2;
    localparam int MW_ADD = 2 * COORD_WIDTH + 20;
    localparam int MW_A   = (MW_DET > MW_INV) ? MW_DET : MW_INV;
    localparam int MW     = (MW_A > MW_ADD) ? MW_A : MW_ADD;
    localparam int SW     = MW + 1;
    localparam int MB_W   = (ACC_WIDTH > COORD_WIDTH) ? ACC_WIDTH : COORD_WIDTH;

    localparam logic signed [SW-1:0] SAT_HI =
        {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO =
        {{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

    function automatic logic signed [ACC_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
        if (v > SAT_HI)
        begin
            return SAT_HI[ACC_WIDTH-1:0];
        end
        else if (v < SAT_LO)
        begin
            return SAT_LO[ACC_WIDTH-1:0];
        end
        return v[ACC_WIDTH-1:0];
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] n;
        n = -v;
        return v[SW-1] ? n[MW-1:0] : v[MW-1:0];
    endfunction

    // sequencer state
    wlsq_pkg::state_t            state_reg, state_next;
    logic [3:0]                  step_reg, step_next;
    wlsq_pkg::opcode_t           op_reg, op_next;
    logic                        sing_reg, sing_next;
    logic                        neg_reg, neg_next;

    // matrix, cofactors, working values
    logic signed [ACC_WIDTH-1:0]   ent_reg [6];
    logic signed [ACC_WIDTH-1:0]   ent_next [6];
    logic signed [SW-1:0]          cof_reg [6];
    logic signed [SW-1:0]          cof_next [6];
    logic signed [SW-1:0]          det_reg, det_next;
    logic signed [SW-1:0]          acc_reg, acc_next;
    logic signed [COORD_WIDTH-1:0] vec_reg [3];
    logic signed [COORD_WIDTH-1:0] vec_next [3];
    logic [MW-1:0]                 len_reg, len_next;
    logic [MW-1:0]                 opa_reg, opa_next;

    // pending result and output register
    logic                          pkind_reg, pkind_next;
    logic                          psing_reg, psing_next;
    logic signed [ACC_WIDTH-1:0]   pgrad_reg [3];
    logic signed [ACC_WIDTH-1:0]   pgrad_next [3];
    logic                          out_valid_reg, out_valid_next;
    logic                          okind_reg, okind_next;
    logic                          osing_reg, osing_next;
    logic signed [GW-1:0]          ograd_reg [3];
    logic signed [GW-1:0]          ograd_next [3];

    // shared unit
    wlsq_pkg::alu_req_t   alu_req;
    wlsq_pkg::alu_rsp_t   alu_rsp;
    logic [MW-1:0]        alu_a;
    logic [MW-1:0]        alu_b;
    logic [MW-1:0]        alu_res;

    // operand file read port
    wlsq_pkg::mac_t       mac;
    logic [3:0]           fsel;
    logic signed [SW-1:0] fval;

    assign mac = wlsq_pkg::mac_entry(op_reg, step_reg);

    always_comb
    begin
        case (state_reg)
            wlsq_pkg::S_MUL_A:    fsel = mac.a_sel;
            wlsq_pkg::S_MUL_GO:   fsel = mac.b_sel;
            wlsq_pkg::S_DIV_GO:   fsel = wlsq_pkg::F_COF + step_reg;
            wlsq_pkg::S_DIV_WAIT: fsel = wlsq_pkg::F_ENT + step_reg - 4'd3;
            default:              fsel = wlsq_pkg::F_ENT;
        endcase
    end

    always_comb
    begin
        logic [3:0] idx;
        idx = '0;
        if (fsel < wlsq_pkg::F_COF)
        begin
            fval = SW'(ent_reg[fsel[2:0]]);
        end
        else if (fsel < wlsq_pkg::F_VEC)
        begin
            idx  = fsel - wlsq_pkg::F_COF;
            fval = cof_reg[idx[2:0]];
        end
        else
        begin
            idx  = fsel - wlsq_pkg::F_VEC;
            fval = SW'(vec_reg[idx[1:0]]);
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] res_s;
        logic signed [SW-1:0] acc_sum;
        logic [3:0]           didx;
        logic [1:0]           row;
        state_next     = state_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        sing_next      = sing_reg;
        neg_next       = neg_reg;
        ent_next       = ent_reg;
        cof_next       = cof_reg;
        det_next       = det_reg;
        acc_next       = acc_reg;
        vec_next       = vec_reg;
        len_next       = len_reg;
        opa_next       = opa_reg;
        pkind_next     = pkind_reg;
        psing_next     = psing_reg;
        pgrad_next     = pgrad_reg;
        okind_next     = okind_reg;
        osing_next     = osing_reg;
        ograd_next     = ograd_reg;
        out_valid_next = out_valid_reg & out_stall;
        alu_req.start  = 1'b0;
        alu_req.op     = wlsq_pkg::ALU_MUL;
        alu_a          = '0;
        alu_b          = '0;
        in_stall       = (state_reg != wlsq_pkg::S_IDLE);

        // signed view of the unit's product or quotient
        res_s   = neg_reg ? -$signed({1'b0, alu_res}) : $signed({1'b0, alu_res});
        acc_sum = (mac.first ? SW'(0) : acc_reg) + res_s;
        didx    = step_reg - 4'd3;
        row     = (step_reg == 4'd2) ? 2'd0 : ((step_reg == 4'd5) ? 2'd1 : 2'd2);

        case (state_reg)
            wlsq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    vec_next[0] = vec_x;
                    vec_next[1] = vec_y;
                    vec_next[2] = vec_z;
                    op_next     = wlsq_pkg::opcode_t'(opcode);
                    step_next   = '0;
                    case (wlsq_pkg::opcode_t'(opcode))
                        wlsq_pkg::OP_CLEAR:
                        begin
                            for (int i = 0; i < 6; i++)
                            begin
                                ent_next[i] = '0;
                            end
                            sing_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = wlsq_pkg::S_MUL_A;
                        end
                    endcase
                end
            end
            wlsq_pkg::S_MUL_A:
            begin
                opa_next   = mag(fval);
                neg_next   = fval[SW-1] ^ mac.sub;
                state_next = wlsq_pkg::S_MUL_GO;
            end
            wlsq_pkg::S_MUL_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = wlsq_pkg::ALU_MUL;
                alu_a         = opa_reg;
                alu_b         = mag(fval);
                neg_next      = neg_reg ^ fval[SW-1];
                state_next    = wlsq_pkg::S_MUL_WAIT;
            end
            wlsq_pkg::S_MUL_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    acc_next = acc_sum;
                    if (!mac.last)
                    begin
                        step_next  = step_reg + 4'd1;
                        state_next = wlsq_pkg::S_MUL_A;
                    end
                    else
                    begin
                        case (op_reg)
                            wlsq_pkg::OP_ADD:
                            begin
                                if (step_reg == wlsq_pkg::ADD_SUMSQ_LAST)
                                begin
                                    // zero-length offset leaves the matrix alone
                                    state_next = (acc_sum == '0) ? wlsq_pkg::S_IDLE
                                                                 : wlsq_pkg::S_ROOT_GO;
                                end
                                else
                                begin
                                    state_next = wlsq_pkg::S_DIV_GO;
                                end
                            end
                            wlsq_pkg::OP_INVERT:
                            begin
                                if (step_reg == wlsq_pkg::INV_DET_LAST)
                                begin
                                    det_next = acc_sum;
                                    if (acc_sum == '0)
                                    begin
                                        for (int i = 0; i < 6; i++)
                                        begin
                                            ent_next[i] = '0;
                                        end
                                        sing_next  = 1'b1;
                                        pkind_next = 1'b0;
                                        psing_next = 1'b1;
                                        for (int i = 0; i < 3; i++)
                                        begin
                                            pgrad_next[i] = '0;
                                        end
                                        state_next = wlsq_pkg::S_OUT;
                                    end
                                    else
                                    begin
                                        step_next  = '0;
                                        state_next = wlsq_pkg::S_DIV_GO;
                                    end
                                end
                                else
                                begin
                                    cof_next[step_reg[3:1]] = acc_sum;
                                    step_next  = step_reg + 4'd1;
                                    state_next = wlsq_pkg::S_MUL_A;
                                end
                            end
                            wlsq_pkg::OP_APPLY:
                            begin
                                pgrad_next[row] = sat(acc_sum >>> wlsq_pkg::IN_FRAC);
                                if (step_reg == wlsq_pkg::APPLY_LAST)
                                begin
                                    pkind_next = 1'b1;
                                    psing_next = sing_reg;
                                    state_next = wlsq_pkg::S_OUT;
                                end
                                else
                                begin
                                    step_next  = step_reg + 4'd1;
                                    state_next = wlsq_pkg::S_MUL_A;
                                end
                            end
                            default:
                            begin
                                state_next = wlsq_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end
            wlsq_pkg::S_ROOT_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = wlsq_pkg::ALU_SQRT;
                alu_a         = mag(acc_reg);
                state_next    = wlsq_pkg::S_ROOT_WAIT;
            end
            wlsq_pkg::S_ROOT_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    len_next   = alu_res;
                    step_next  = step_reg + 4'd1;
                    state_next = wlsq_pkg::S_MUL_A;
                end
            end
            wlsq_pkg::S_DIV_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = wlsq_pkg::ALU_DIV;
                if (op_reg == wlsq_pkg::OP_ADD)
                begin
                    // weighted term: product scaled to Q32.32 over the length
                    alu_a    = mag(acc_reg) << (wlsq_pkg::ACC_FRAC - wlsq_pkg::IN_FRAC);
                    alu_b    = len_reg;
                    neg_next = acc_reg[SW-1];
                end
                else
                begin
                    alu_a    = mag(fval) << (2 * wlsq_pkg::ACC_FRAC);
                    alu_b    = mag(det_reg);
                    neg_next = fval[SW-1] ^ det_reg[SW-1];
                end
                state_next = wlsq_pkg::S_DIV_WAIT;
            end
            wlsq_pkg::S_DIV_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (op_reg == wlsq_pkg::OP_ADD)
                    begin
                        ent_next[didx[2:0]] = sat(fval + res_s);
                        if (step_reg == wlsq_pkg::ADD_LAST)
                        begin
                            state_next = wlsq_pkg::S_IDLE;
                        end
                        else
                        begin
                            step_next  = step_reg + 4'd1;
                            state_next = wlsq_pkg::S_MUL_A;
                        end
                    end
                    else
                    begin
                        ent_next[step_reg[2:0]] = sat(res_s);
                        if (step_reg == wlsq_pkg::INV_DIV_LAST)
                        begin
                            sing_next  = 1'b0;
                            pkind_next = 1'b0;
                            psing_next = 1'b0;
                            for (int i = 0; i < 3; i++)
                            begin
                                pgrad_next[i] = '0;
                            end
                            state_next = wlsq_pkg::S_OUT;
                        end
                        else
                        begin
                            step_next  = step_reg + 4'd1;
                            state_next = wlsq_pkg::S_DIV_GO;
                        end
                    end
                end
            end
            wlsq_pkg::S_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    okind_next     = pkind_reg;
                    osing_next     = psing_reg;
                    for (int i = 0; i < 3; i++)
                    begin
                        ograd_next[i] = GW'(pgrad_reg[i]);
                    end
                    state_next = wlsq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wlsq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wlsq_pkg::S_IDLE;
            step_reg      <= '0;
            op_reg        <= wlsq_pkg::OP_CLEAR;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                ent_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            op_reg        <= op_next;
            sing_reg      <= sing_next;
            out_valid_reg <= out_valid_next;
            ent_reg       <= ent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        cof_reg   <= cof_next;
        det_reg   <= det_next;
        acc_reg   <= acc_next;
        vec_reg   <= vec_next;
        len_reg   <= len_next;
        opa_reg   <= opa_next;
        pkind_reg <= pkind_next;
        psing_reg <= psing_next;
        pgrad_reg <= pgrad_next;
        okind_reg <= okind_next;
        osing_reg <= osing_next;
        ograd_reg <= ograd_next;
    end

    wlsq_alu #(
        .MW   (MW),
        .MB_W (MB_W),
        .SQ_N (COORD_WIDTH)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (alu_a),
        .b     (alu_b),
        .rsp   (alu_rsp),
        .res   (alu_res)
    );

    assign out_valid   = out_valid_reg;
    assign result_kind = okind_reg;
    assign singular    = osing_reg;
    assign grad_x      = ograd_reg[0];
    assign grad_y      = ograd_reg[1];
    assign grad_z      = ograd_reg[2];

    // the shared unit is never restarted mid-operation
    a_alu_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("shared unit started while busy");

    // unit results only arrive while the sequencer waits for them
    a_alu_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == wlsq_pkg::S_MUL_WAIT ||
                          state_reg == wlsq_pkg::S_ROOT_WAIT ||
                          state_reg == wlsq_pkg::S_DIV_WAIT))
        else $error("shared unit result with nobody waiting");

    // a new result is only loaded from the output hand-off state
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == wlsq_pkg::S_OUT))
        else $error("result appeared outside hand-off");

    // invert status carries a zero gradient
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_kind) |-> (grad_x == '0 && grad_y == '0 && grad_z == '0))
        else $error("invert status with non-zero gradient");

endmodule
